// ===== rtl/twhm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twhm_pkg: shared types and constants of the trigger window hit matcher
// Register indexes, word field positions, result kinds and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package twhm_pkg;

  localparam int HIT_DEPTH_DEF = 32;

  // configuration port
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_OFFSET = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_WIDTH  = 8'd1;
  localparam logic [31:0] WINDOW_OFFSET_RST = 32'd0;
  localparam logic [15:0] WINDOW_WIDTH_RST  = 16'd1;

  // result fields
  localparam int TOTAL_W = 6;
  localparam logic KIND_HIT = 1'b0;
  localparam logic KIND_HDR = 1'b1;

  // data word layout
  localparam int HIT_FLAG_BIT = 0;
  localparam int TRIG_NUM_LSB = 1;
  localparam int TRIG_NUM_MSB = 24;
  localparam int FINE_LSB     = 25;
  localparam int FINE_MSB     = 27;
  localparam int STATUS_LSB   = 28;
  localparam int STATUS_MSB   = 31;

  typedef struct packed {
    logic ins_hit;    // insert the input word into the hit store
    logic cap_trig;   // latch trigger word, window start and underflow
    logic calc_end;   // register the window end
    logic calc_cnt;   // register drop and match counts
    logic load_hdr;   // load header into the output register
    logic drop_one;   // shift the store down by one, no result
    logic load_hit;   // load head hit into the output register and shift
  } twhm_cmd_t;

  typedef struct packed {
    logic word_hit;
    logic word_trig;
    logic out_free;
    logic drop_zero;
    logic emit_zero;
  } twhm_sts_t;

endpackage

// ===== rtl/twhm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twhm_ctrl: sequencer of the trigger window hit matcher
// Accepts words while idle and steps a trigger through window setup,
// header, discard of early hits and emission of matched hits.
// ----------------------------------------------------------------------------
module twhm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  twhm_pkg::twhm_sts_t sts,
  output twhm_pkg::twhm_cmd_t cmd
);
  import twhm_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_END  = 6'b000010,
    ST_CNT  = 6'b000100,
    ST_HDR  = 6'b001000,
    ST_DROP = 6'b010000,
    ST_EMIT = 6'b100000
  } twhm_state_t;

  twhm_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (sts.word_hit) begin
            cmd.ins_hit = 1'b1;
          end else if (sts.word_trig) begin
            cmd.cap_trig = 1'b1;
            state_nxt    = ST_END;
          end
        end
      end
      ST_END: begin
        cmd.calc_end = 1'b1;
        state_nxt    = ST_CNT;
      end
      ST_CNT: begin
        cmd.calc_cnt = 1'b1;
        state_nxt    = ST_HDR;
      end
      ST_HDR: begin
        if (sts.out_free) begin
          cmd.load_hdr = 1'b1;
          state_nxt    = ST_DROP;
        end
      end
      ST_DROP: begin
        if (sts.drop_zero) begin
          state_nxt = ST_EMIT;
        end else begin
          cmd.drop_one = 1'b1;
        end
      end
      ST_EMIT: begin
        if (sts.emit_zero) begin
          state_nxt = ST_IDLE;
        end else if (sts.out_free) begin
          cmd.load_hit = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/twhm_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twhm_datapath: hit store, window arithmetic and result register
// The store is a row of sorted cells: insertion shifts cells up, removal
// shifts them down by one; every cell compares against the window bounds.
// ----------------------------------------------------------------------------
module twhm_datapath #(
  parameter int HIT_DEPTH = twhm_pkg::HIT_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [twhm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  input  logic [31:0]                   in_data_word,
  input  logic [31:0]                   in_bunch_count,
  input  logic                          out_stall,
  input  twhm_pkg::twhm_cmd_t           cmd,
  output twhm_pkg::twhm_sts_t           sts,
  output logic                          out_valid,
  output logic                          out_kind,
  output logic [31:0]                   out_trigger_bunch,
  output logic [23:0]                   out_trigger_number,
  output logic [2:0]                    out_fine_bunch,
  output logic [3:0]                    out_status_nibble,
  output logic [twhm_pkg::TOTAL_W-1:0]  out_hit_total,
  output logic                          out_hits_lost,
  output logic [31:0]                   out_hit_word,
  output logic                          out_last
);
  import twhm_pkg::*;

  localparam int CNT_W = $clog2(HIT_DEPTH + 1);

  // configuration
  logic [31:0] offset_r;
  logic [15:0] width_r;

  // hit store cells
  logic [31:0]          cell_bunch_r [HIT_DEPTH];
  logic [31:0]          cell_data_r  [HIT_DEPTH];
  logic [HIT_DEPTH-1:0] cell_valid_r;
  logic [31:0]          bunch_nxt    [HIT_DEPTH];
  logic [31:0]          data_nxt     [HIT_DEPTH];
  logic [HIT_DEPTH-1:0] valid_nxt;
  logic [HIT_DEPTH-1:0] le_new;
  logic [HIT_DEPTH-1:0] lt_start;
  logic [HIT_DEPTH-1:0] lt_end;
  logic                 store_full;
  logic                 lost_r;

  // trigger
  logic [31:0]      trig_word_r;
  logic [31:0]      trig_bunch_r;
  logic [31:0]      start_r;
  logic [32:0]      end_r;
  logic             under_r;
  logic [CNT_W-1:0] drop_cnt_r;
  logic [CNT_W-1:0] emit_cnt_r;
  logic [CNT_W-1:0] n_cnt, lo_cnt, hi_cnt;

  // result register
  logic                out_valid_r;
  logic                kind_r;
  logic [31:0]         tbunch_r;
  logic [23:0]         tnum_r;
  logic [2:0]          fine_r;
  logic [3:0]          status_r;
  logic [TOTAL_W-1:0]  total_r;
  logic                lost_out_r;
  logic [31:0]         hword_r;
  logic                last_r;

  // length of the set prefix of a thermometer vector
  function automatic logic [CNT_W-1:0] prefix_len(input logic [HIT_DEPTH-1:0] t);
    logic [CNT_W-1:0] c;
    c = '0;
    for (int i = 0; i < HIT_DEPTH; i++) begin
      if (t[i]) c = CNT_W'(i + 1);
    end
    return c;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= WINDOW_OFFSET_RST;
      width_r  <= WINDOW_WIDTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WINDOW_OFFSET: offset_r <= cfg_data;
        CFG_WINDOW_WIDTH:  width_r  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign store_full = cell_valid_r[HIT_DEPTH-1];

  always_comb begin
    for (int i = 0; i < HIT_DEPTH; i++) begin
      le_new[i]   = cell_valid_r[i] && (cell_bunch_r[i] <= in_bunch_count);
      lt_start[i] = cell_valid_r[i] && (cell_bunch_r[i] < start_r);
      lt_end[i]   = cell_valid_r[i] && ({1'b0, cell_bunch_r[i]} < end_r);
    end
  end

  // next contents of each cell
  always_comb begin
    for (int i = 0; i < HIT_DEPTH; i++) begin
      bunch_nxt[i] = cell_bunch_r[i];
      data_nxt[i]  = cell_data_r[i];
      valid_nxt[i] = cell_valid_r[i];
      if (cmd.ins_hit && !store_full) begin
        if (!le_new[i]) begin
          if (i == 0) begin
            bunch_nxt[i] = in_bunch_count;
            data_nxt[i]  = in_data_word;
          end else if (le_new[i-1]) begin
            bunch_nxt[i] = in_bunch_count;
            data_nxt[i]  = in_data_word;
          end else begin
            bunch_nxt[i] = cell_bunch_r[i-1];
            data_nxt[i]  = cell_data_r[i-1];
          end
        end
        if (i == 0) begin
          valid_nxt[i] = 1'b1;
        end else begin
          valid_nxt[i] = cell_valid_r[i] | cell_valid_r[i-1];
        end
      end else if (cmd.drop_one || cmd.load_hit) begin
        if (i == HIT_DEPTH - 1) begin
          valid_nxt[i] = 1'b0;
        end else begin
          bunch_nxt[i] = cell_bunch_r[i+1];
          data_nxt[i]  = cell_data_r[i+1];
          valid_nxt[i] = cell_valid_r[i+1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < HIT_DEPTH; i++) begin
      cell_bunch_r[i] <= bunch_nxt[i];
      cell_data_r[i]  <= data_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_valid_r <= '0;
      lost_r       <= 1'b0;
    end else begin
      cell_valid_r <= valid_nxt;
      if (cmd.ins_hit && store_full) begin
        lost_r <= 1'b1;
      end else if (cmd.load_hdr) begin
        lost_r <= 1'b0;
      end
    end
  end

  // window setup: start and underflow at capture, end in the following cycle
  always_ff @(posedge clk) begin
    if (cmd.cap_trig) begin
      trig_word_r  <= in_data_word;
      trig_bunch_r <= in_bunch_count;
      start_r      <= in_bunch_count - offset_r;
      under_r      <= (in_bunch_count < offset_r);
    end
    if (cmd.calc_end) begin
      end_r <= {1'b0, start_r} + {17'd0, width_r};
    end
  end

  assign n_cnt  = prefix_len(cell_valid_r);
  assign lo_cnt = under_r ? n_cnt : prefix_len(lt_start);
  assign hi_cnt = under_r ? n_cnt : prefix_len(lt_end);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drop_cnt_r <= '0;
      emit_cnt_r <= '0;
    end else begin
      if (cmd.calc_cnt) begin
        drop_cnt_r <= lo_cnt;
        emit_cnt_r <= hi_cnt - lo_cnt;
      end else begin
        if (cmd.drop_one) drop_cnt_r <= drop_cnt_r - CNT_W'(1);
        if (cmd.load_hit) emit_cnt_r <= emit_cnt_r - CNT_W'(1);
      end
    end
  end

  // result register: load on command, release when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_hdr || cmd.load_hit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_hdr) begin
      kind_r     <= KIND_HDR;
      tbunch_r   <= trig_bunch_r;
      tnum_r     <= trig_word_r[TRIG_NUM_MSB:TRIG_NUM_LSB];
      fine_r     <= trig_word_r[FINE_MSB:FINE_LSB];
      status_r   <= trig_word_r[STATUS_MSB:STATUS_LSB];
      total_r    <= TOTAL_W'(emit_cnt_r);
      lost_out_r <= lost_r;
      hword_r    <= '0;
      last_r     <= (emit_cnt_r == '0);
    end else if (cmd.load_hit) begin
      kind_r     <= KIND_HIT;
      tbunch_r   <= '0;
      tnum_r     <= '0;
      fine_r     <= '0;
      status_r   <= '0;
      total_r    <= '0;
      lost_out_r <= 1'b0;
      hword_r    <= cell_data_r[0];
      last_r     <= (emit_cnt_r == CNT_W'(1));
    end
  end

  assign sts.word_hit  = in_data_word[HIT_FLAG_BIT];
  assign sts.word_trig = (in_data_word != '0) && !in_data_word[HIT_FLAG_BIT];
  assign sts.out_free  = !out_valid_r || !out_stall;
  assign sts.drop_zero = (drop_cnt_r == '0);
  assign sts.emit_zero = (emit_cnt_r == '0);

  assign out_valid          = out_valid_r;
  assign out_kind           = kind_r;
  assign out_trigger_bunch  = tbunch_r;
  assign out_trigger_number = tnum_r;
  assign out_fine_bunch     = fine_r;
  assign out_status_nibble  = status_r;
  assign out_hit_total      = total_r;
  assign out_hits_lost      = lost_out_r;
  assign out_hit_word       = hword_r;
  assign out_last           = last_r;

endmodule

// ===== rtl/trigger_window_hit_matcher_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trigger_window_hit_matcher_unit: match stored hits to trigger windows
// Buffers hit words sorted by bunch count and, for each trigger word,
// emits a header and the hits inside the trigger's bunch window.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake           payload
//  in_      in   in_valid/in_stall   data_word, bunch_count
//  out_     out  out_valid/out_stall kind, trigger_bunch, trigger_number,
//                                    fine_bunch, status_nibble, hit_total,
//                                    hits_lost, hit_word, last
//  cfg_     in   cfg_valid/cfg_ready index, data (0 offset, 1 width)
//
//  Hit and zero words are taken one per cycle while no trigger stalls the
//  input; a hit is inserted into the sorted cell row in the cycle it is
//  accepted, or is dropped and flagged as lost when the store is full.
//  A trigger stalls the input while the window end and the drop and emit
//  counts are registered, the header is loaded, the hits below the window
//  start are dropped and the hits inside the window are emitted.
//  Output stalls only add wait cycles in the header and emit steps.
//  Reset empties the store at once; no clearing pass follows.
//
module trigger_window_hit_matcher_unit #(
  parameter int HIT_DEPTH = twhm_pkg::HIT_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [twhm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [31:0]                    in_data_word,
  input  logic [31:0]                    in_bunch_count,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_kind,
  output logic [31:0]                    out_trigger_bunch,
  output logic [23:0]                    out_trigger_number,
  output logic [2:0]                     out_fine_bunch,
  output logic [3:0]                     out_status_nibble,
  output logic [twhm_pkg::TOTAL_W-1:0]   out_hit_total,
  output logic                           out_hits_lost,
  output logic [31:0]                    out_hit_word,
  output logic                           out_last
);
  import twhm_pkg::*;

  twhm_cmd_t cmd;
  twhm_sts_t sts;

  assign cfg_ready = 1'b1;

  twhm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  twhm_datapath #(
    .HIT_DEPTH (HIT_DEPTH)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_valid && cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_data_word       (in_data_word),
    .in_bunch_count     (in_bunch_count),
    .out_stall          (out_stall),
    .cmd                (cmd),
    .sts                (sts),
    .out_valid          (out_valid),
    .out_kind           (out_kind),
    .out_trigger_bunch  (out_trigger_bunch),
    .out_trigger_number (out_trigger_number),
    .out_fine_bunch     (out_fine_bunch),
    .out_status_nibble  (out_status_nibble),
    .out_hit_total      (out_hit_total),
    .out_hits_lost      (out_hits_lost),
    .out_hit_word       (out_hit_word),
    .out_last           (out_last)
  );

  // a trigger blocks the input while its window is worked out
  a_trig_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data_word != '0 && !in_data_word[HIT_FLAG_BIT])
      |=> in_stall)
    else $error("input not held after trigger transaction");

  // an empty window closes on its header
  a_hdr_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_HDR && out_hit_total == '0) |-> out_last)
    else $error("empty header without last");

  a_hdr_busy_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_HDR && out_hit_total != '0) |-> !out_last)
    else $error("header with hits marked last");

  a_hit_fields_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_HIT)
      |-> (out_trigger_bunch == '0 && out_hit_total == '0 && !out_hits_lost))
    else $error("hit transaction carries header fields");

endmodule
